/* rtl/vpv_pkg.sv */
// Shared types, constants and the clamp helper for the vertex projection pipeline.
`timescale 1ns / 1ps
package vpv_pkg;

  localparam int VPV_XW      = 32;
  localparam int VPV_CFG_AW  = 4;
  localparam int VPV_NUM_REGS = 8;

  localparam logic [VPV_CFG_AW-1:0] REG_ROW_X_LO = 4'd0;
  localparam logic [VPV_CFG_AW-1:0] REG_ROW_X_HI = 4'd1;
  localparam logic [VPV_CFG_AW-1:0] REG_ROW_Y_LO = 4'd2;
  localparam logic [VPV_CFG_AW-1:0] REG_ROW_Y_HI = 4'd3;
  localparam logic [VPV_CFG_AW-1:0] REG_ROW_W_LO = 4'd4;
  localparam logic [VPV_CFG_AW-1:0] REG_ROW_W_HI = 4'd5;
  localparam logic [VPV_CFG_AW-1:0] REG_VP_ORIGIN = 4'd6;
  localparam logic [VPV_CFG_AW-1:0] REG_VP_SIZE  = 4'd7;

  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = VPV_XW / DIV_BITS;

  localparam logic signed [71:0] CLAMP_MAX = 72'sd2147483647;
  localparam logic signed [71:0] CLAMP_MIN = -72'sd2147483648;
  localparam logic signed [31:0] INT32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic              sat;
    logic signed [31:0] val;
  } vpv_sat_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               neg;
    logic               wzero;
    logic               ovf;
    logic               sat;
    logic [31:0]        dvs;
    logic [31:0]        rem;
    logic [31:0]        quo;
  } vpv_div_t;

  function automatic vpv_sat_t vpv_clamp32(input logic signed [71:0] v);
    vpv_sat_t r;
    if (v > CLAMP_MAX) begin
      r.sat = 1'b1;
      r.val = INT32_MAX;
    end else if (v < CLAMP_MIN) begin
      r.sat = 1'b1;
      r.val = INT32_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/vertex_project_to_viewport.sv */
// Vertex transform, perspective divide and viewport map, fully pipelined.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+------------------------------------
//  s_axis   | in        | s_axis_tvalid / tready       | tdata: point_x, point_y, point_z
//  m_axis   | out       | m_axis_tvalid / tready       | tdata: screen_x, screen_y;
//           |           |                              | tuser: w_was_zero, saturated
//  cfg      | in        | cfg_valid_i / cfg_ready_o    | cfg_addr_i index, cfg_data_i value
//
// One item per cycle unless the output stalls; stages: clip rows, 8-stage radix-2 reciprocal
// divider at 4 quotient bits per stage, normalize, viewport map, output register.
// Reset clears all stage valid bits and loads the default transform.
// Each stage holds while the one after it is full and stalled; bubbles close up.
// Configuration writes are always ready.
`timescale 1ns / 1ps
module vertex_project_to_viewport import vpv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [95:0]           s_axis_tdata,   // point_x, point_y, point_z
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [63:0]           m_axis_tdata,   // screen_x, screen_y
  output logic [1:0]            m_axis_tuser,   // w_was_zero, saturated
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [VPV_CFG_AW-1:0] cfg_addr_i,
  input  logic [63:0]           cfg_data_i
);

  localparam int ST_MUL  = 0;
  localparam int ST_SUM  = 1;
  localparam int ST_CLIP = 2;
  localparam int ST_PREP = 3;
  localparam int ST_RCP  = ST_PREP + DIV_STAGES + 1;
  localparam int ST_NMUL = ST_RCP + 1;
  localparam int ST_NORM = ST_NMUL + 1;
  localparam int ST_VMUL = ST_NORM + 1;
  localparam int ST_OUT  = ST_VMUL + 1;
  localparam int NS      = ST_OUT + 1;

  localparam logic [63:0]        NUMER = 64'd1 << (2 * FRAC_BITS);
  localparam logic signed [63:0] ONE   = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [33:0] ONE34 = ONE[33:0];
  localparam logic signed [34:0] ONE35 = ONE[34:0];

  // configuration registers
  logic [63:0] cfg_q [VPV_NUM_REGS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_ROW_X_LO[2:0]]  <= 64'h0000_0001_0000_0000;
      cfg_q[REG_ROW_X_HI[2:0]]  <= 64'h0;
      cfg_q[REG_ROW_Y_LO[2:0]]  <= 64'h0001_0000_0000_0000;
      cfg_q[REG_ROW_Y_HI[2:0]]  <= 64'h0;
      cfg_q[REG_ROW_W_LO[2:0]]  <= 64'h0;
      cfg_q[REG_ROW_W_HI[2:0]]  <= 64'h0001_0000_0000_0000;
      cfg_q[REG_VP_ORIGIN[2:0]] <= 64'h0;
      cfg_q[REG_VP_SIZE[2:0]]   <= 64'h0;
    end else if (cfg_valid_i && (cfg_addr_i <= REG_VP_SIZE)) begin
      if (cfg_addr_i >= REG_VP_ORIGIN) begin
        cfg_q[cfg_addr_i[2:0]] <= {32'h0, cfg_data_i[31:0]};
      end else begin
        cfg_q[cfg_addr_i[2:0]] <= cfg_data_i;
      end
    end
  end

  logic signed [31:0] row_e [3][4];
  logic signed [15:0] vp_left, vp_bottom;
  logic [15:0]        vp_w, vp_h;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_e[r][0] = cfg_q[2*r][31:0];
      row_e[r][1] = cfg_q[2*r][63:32];
      row_e[r][2] = cfg_q[2*r+1][31:0];
      row_e[r][3] = cfg_q[2*r+1][63:32];
    end
  end

  assign vp_left   = cfg_q[REG_VP_ORIGIN[2:0]][15:0];
  assign vp_bottom = cfg_q[REG_VP_ORIGIN[2:0]][31:16];
  assign vp_w      = cfg_q[REG_VP_SIZE[2:0]][15:0];
  assign vp_h      = cfg_q[REG_VP_SIZE[2:0]][31:16];

  // stage valids and per-stage enables
  logic [NS-1:0] vld_q;
  logic [NS-1:0] vld_up;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = m_axis_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign vld_up        = {vld_q[NS-2:0], s_axis_tvalid};
  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_up[k];
        end
      end
    end
  end

  // products of the three rows
  logic signed [31:0] pt [3];
  logic signed [63:0] prod_d [3][3];
  logic signed [63:0] prod_q [3][3];

  assign pt[0] = s_axis_tdata[31:0];
  assign pt[1] = s_axis_tdata[63:32];
  assign pt[2] = s_axis_tdata[95:64];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = row_e[r][c] * pt[c];
      end
    end
  end

  // row sums
  logic signed [65:0] sum_d [3];
  logic signed [65:0] sum_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = 66'(prod_q[r][0]) + 66'(prod_q[r][1]) + 66'(prod_q[r][2]);
    end
  end

  // clip coordinates
  logic signed [65:0] clip_sum [3];
  vpv_sat_t           clip_c [3];
  logic signed [31:0] clip_q [3];
  logic               clip_sat_d, clip_sat_q;

  always_comb begin
    clip_sat_d = 1'b0;
    for (int r = 0; r < 3; r++) begin
      clip_sum[r] = (sum_q[r] >>> FRAC_BITS) + 66'(row_e[r][3]);
      clip_c[r]   = vpv_clamp32(72'(clip_sum[r]));
      clip_sat_d  = clip_sat_d | clip_c[r].sat;
    end
  end

  // divider setup and stages
  vpv_div_t div_pre;
  vpv_div_t div_q   [DIV_STAGES+1];
  vpv_div_t div_nxt [DIV_STAGES+1];

  always_comb begin
    div_pre.cx    = clip_q[0];
    div_pre.cy    = clip_q[1];
    div_pre.neg   = clip_q[2][31];
    div_pre.wzero = (clip_q[2] == 32'sd0);
    div_pre.dvs   = clip_q[2][31] ? (~clip_q[2] + 32'd1) : clip_q[2];
    div_pre.ovf   = ({div_pre.dvs, 32'h0} <= NUMER);
    div_pre.rem   = NUMER[63:32];
    div_pre.quo   = '0;
    div_pre.sat   = clip_sat_q;
  end

  assign div_nxt[0] = div_pre;

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    localparam int BASE = VPV_XW - 1 - j * DIV_BITS;
    vpv_div_t    nxt;
    logic [32:0] trial [DIV_BITS];

    always_comb begin
      nxt = div_q[j];
      for (int s = 0; s < DIV_BITS; s++) begin
        trial[s] = {nxt.rem, NUMER[6'(BASE - s)]};
        if (trial[s] >= {1'b0, nxt.dvs}) begin
          nxt.rem               = 32'(trial[s] - {1'b0, nxt.dvs});
          nxt.quo[5'(BASE - s)] = 1'b1;
        end else begin
          nxt.rem = trial[s][31:0];
        end
      end
    end

    assign div_nxt[j+1] = nxt;
  end

  // reciprocal clamp
  vpv_div_t           dv;
  logic signed [31:0] rcp_r_d, rcp_r_q;
  logic               rcp_sat_d, rcp_sat_q;
  logic signed [31:0] rcp_cx_q, rcp_cy_q;
  logic               rcp_wz_q;

  assign dv = div_q[DIV_STAGES];

  always_comb begin
    rcp_sat_d = dv.sat;
    if (dv.wzero) begin
      rcp_r_d = '0;
    end else if (dv.neg) begin
      if (dv.ovf || (dv.quo > 32'h8000_0000)) begin
        rcp_r_d   = INT32_MIN;
        rcp_sat_d = 1'b1;
      end else begin
        rcp_r_d = ~dv.quo + 32'd1;
      end
    end else if (dv.ovf || dv.quo[31]) begin
      rcp_r_d   = INT32_MAX;
      rcp_sat_d = 1'b1;
    end else begin
      rcp_r_d = dv.quo;
    end
  end

  // scale by reciprocal
  logic signed [63:0] nm_x_d, nm_y_d, nm_x_q, nm_y_q;
  logic               nm_wz_q, nm_sat_q;

  assign nm_x_d = rcp_cx_q * rcp_r_q;
  assign nm_y_d = rcp_cy_q * rcp_r_q;

  // normalized coordinates
  vpv_sat_t           nrm_cx, nrm_cy;
  logic signed [31:0] nx_d, ny_d, nx_q, ny_q;
  logic               nrm_sat_d, nrm_sat_q, nrm_wz_q;

  always_comb begin
    nrm_cx = vpv_clamp32(72'(nm_x_q >>> FRAC_BITS));
    nrm_cy = vpv_clamp32(72'(nm_y_q >>> FRAC_BITS));
    if (nm_wz_q) begin
      nx_d      = '0;
      ny_d      = '0;
      nrm_sat_d = nm_sat_q;
    end else begin
      nx_d      = nrm_cx.val;
      ny_d      = nrm_cy.val;
      nrm_sat_d = nm_sat_q | nrm_cx.sat | nrm_cy.sat;
    end
  end

  // viewport scale
  logic signed [33:0] vm_ax, vm_ty;
  logic signed [34:0] vm_by;
  logic signed [55:0] vx_d, vy_d, vx_q, vy_q;
  logic               vm_wz_q, vm_sat_q;

  always_comb begin
    vm_ax = 34'(nx_q) + ONE34;
    vm_ty = (34'(ny_q) + ONE34) >>> 1;
    vm_by = ONE35 - 35'(vm_ty);
    vx_d  = $signed({1'b0, vp_w}) * vm_ax;
    vy_d  = $signed({1'b0, vp_h}) * vm_by;
  end

  // viewport offset and final clamp
  logic signed [63:0] out_sx, out_sy;
  vpv_sat_t           out_cx, out_cy;
  logic signed [31:0] sx_q, sy_q;
  logic               out_wz_q, out_sat_q;

  always_comb begin
    out_sx = (64'(vp_left) <<< FRAC_BITS) + 64'(vx_q >>> 1);
    out_sy = (64'(vp_bottom) <<< FRAC_BITS) + 64'(vy_q);
    out_cx = vpv_clamp32(72'(out_sx));
    out_cy = vpv_clamp32(72'(out_sy));
  end

  // stage payload registers
  always_ff @(posedge clk_i) begin
    if (en[ST_MUL]) begin
      prod_q <= prod_d;
    end
    if (en[ST_SUM]) begin
      sum_q <= sum_d;
    end
    if (en[ST_CLIP]) begin
      for (int r = 0; r < 3; r++) begin
        clip_q[r] <= clip_c[r].val;
      end
      clip_sat_q <= clip_sat_d;
    end
    for (int j = 0; j <= DIV_STAGES; j++) begin
      if (en[ST_PREP+j]) begin
        div_q[j] <= div_nxt[j];
      end
    end
    if (en[ST_RCP]) begin
      rcp_r_q   <= rcp_r_d;
      rcp_sat_q <= rcp_sat_d;
      rcp_cx_q  <= dv.cx;
      rcp_cy_q  <= dv.cy;
      rcp_wz_q  <= dv.wzero;
    end
    if (en[ST_NMUL]) begin
      nm_x_q   <= nm_x_d;
      nm_y_q   <= nm_y_d;
      nm_wz_q  <= rcp_wz_q;
      nm_sat_q <= rcp_sat_q;
    end
    if (en[ST_NORM]) begin
      nx_q      <= nx_d;
      ny_q      <= ny_d;
      nrm_wz_q  <= nm_wz_q;
      nrm_sat_q <= nrm_sat_d;
    end
    if (en[ST_VMUL]) begin
      vx_q     <= vx_d;
      vy_q     <= vy_d;
      vm_wz_q  <= nrm_wz_q;
      vm_sat_q <= nrm_sat_q;
    end
    if (en[ST_OUT]) begin
      sx_q      <= out_cx.val;
      sy_q      <= out_cy.val;
      out_wz_q  <= vm_wz_q;
      out_sat_q <= vm_sat_q | out_cx.sat | out_cy.sat;
    end
  end

  assign m_axis_tdata = {sy_q, sx_q};
  assign m_axis_tuser = {out_sat_q, out_wz_q};

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output register empty");

  a_div_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_PREP+DIV_STAGES] && !dv.wzero && !dv.ovf) |-> (dv.rem < dv.dvs))
    else $error("divider remainder not below divisor");

  a_rcp_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_RCP] && !en[ST_RCP]) |=> (vld_q[ST_RCP] && $stable(rcp_r_q)))
    else $error("reciprocal stage lost or changed a stalled item");

  a_wzero_no_rcp_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_RCP] && rcp_wz_q) |-> (rcp_r_q == 32'sd0))
    else $error("reciprocal nonzero for zero clip w");

endmodule
